FILE: rtl/spi_ife_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_pkg
// Shared types and constants of the SPI I/O frame exchange master.
// ----------------------------------------------------------------------------
package spi_ife_pkg;

    // Byte position within a frame of up to sixteen bytes.
    localparam int unsigned FIDX_W = 4;
    // Byte counter: counts one past the last byte of the longest frame.
    localparam int unsigned BIDX_W = 5;

    localparam logic [7:0]  TX_MARKER       = 8'h55;
    localparam logic [7:0]  RX_MARKER       = 8'hAA;
    localparam logic [15:0] LINK_TIMEOUT_RST = 16'd100;

    // Commands from the sequencer to the datapath for one tick.
    typedef struct packed {
        logic              build;     // latch the transmit frame contents
        logic              send;      // start a byte on the link this tick
        logic [FIDX_W-1:0] tx_idx;    // transmit frame position to send
        logic              store_rx;  // take the received byte
        logic [FIDX_W-1:0] rx_idx;    // receive frame position of that byte
        logic              check;     // judge the received frame
        logic              select;    // chip select after this tick
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic        send_strobe;
        logic [7:0]  send_byte;
        logic        select_active;
        logic        frame_checked;
        logic        connected;
        logic [7:0]  in_bits_high_volt;
        logic [7:0]  in_bits_low_volt;
        logic [15:0] error_count;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/spi_ife_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_in_if
// Request channel of the frame exchange master: one tick of link status.
// ----------------------------------------------------------------------------
interface spi_ife_in_if;
    logic       valid;
    logic       ready;
    logic       link_ready;
    logic [7:0] received_byte;
    logic [7:0] out_bits_a;
    logic [7:0] out_bits_b;

    modport source (
        output valid, link_ready, received_byte, out_bits_a, out_bits_b,
        input  ready
    );
    modport sink (
        input  valid, link_ready, received_byte, out_bits_a, out_bits_b,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/spi_ife_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_out_if
// Result channel of the frame exchange master: one result per request.
// ----------------------------------------------------------------------------
interface spi_ife_out_if;
    logic        valid;
    logic        ready;
    logic        send_strobe;
    logic [7:0]  send_byte;
    logic        select_active;
    logic        frame_checked;
    logic        connected;
    logic [7:0]  in_bits_high_volt;
    logic [7:0]  in_bits_low_volt;
    logic [15:0] error_count;

    modport source (
        output valid, send_strobe, send_byte, select_active, frame_checked,
               connected, in_bits_high_volt, in_bits_low_volt, error_count,
        input  ready
    );
    modport sink (
        input  valid, send_strobe, send_byte, select_active, frame_checked,
               connected, in_bits_high_volt, in_bits_low_volt, error_count,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/spi_io_frame_exchange.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_io_frame_exchange
// SPI master that trades fixed frames with an I/O board, one step per request.
// ----------------------------------------------------------------------------
// Each request on i_in is one tick of the firmware loop: the link status of
// the byte exchange that just finished and the two output bytes to send. The
// block answers every request with exactly one result on o_out: whether to
// start a byte and which, the chip select level, whether a frame was judged
// this tick, the connection flag, the latched input bytes and the error count.
// A request's result is visible on o_out in the cycle after it is accepted, so
// while the receiver takes each result one request per cycle is sustained; the
// single output register sets that figure. While the receiver stalls, the
// held result stays in the output register and the next request is still
// taken in the cycle the held result leaves. The link timeout register is
// written through i_cfg_we and i_cfg_wdata and resets to 100 ticks. Reset
// returns the sequencer to the frame build phase, clears the link timer,
// connection flag, latched inputs and error count, and empties the output.
// ----------------------------------------------------------------------------
module spi_io_frame_exchange #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    spi_ife_in_if.sink   i_in,
    spi_ife_out_if.source o_out,
    input  wire          i_cfg_we,
    input  wire  [15:0]  i_cfg_wdata
);
    import spi_ife_pkg::*;

    t_cmd        cmd;
    t_result     result_next;
    t_result     result_q;
    logic        step;
    logic        oreg_free;
    logic        oreg_valid;
    logic [7:0]  send_byte;
    logic        link_next;
    logic [7:0]  high_next;
    logic [7:0]  low_next;
    logic [15:0] errors_next;

    // A request is taken whenever the output register can take its result.
    assign i_in.ready = oreg_free;
    assign step       = i_in.valid && oreg_free;

    // The sequencer decides what this tick does to the frame.
    spi_ife_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_link_ready (i_in.link_ready),
        .o_cmd        (cmd)
    );

    // The datapath keeps the frames, checksums, timer and counters.
    spi_ife_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_cmd           (cmd),
        .i_received_byte (i_in.received_byte),
        .i_out_bits_a    (i_in.out_bits_a),
        .i_out_bits_b    (i_in.out_bits_b),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_send_byte     (send_byte),
        .o_link_next     (link_next),
        .o_high_next     (high_next),
        .o_low_next      (low_next),
        .o_errors_next   (errors_next)
    );

    always_comb begin
        result_next.send_strobe       = cmd.send;
        result_next.send_byte         = send_byte;
        result_next.select_active     = cmd.select;
        result_next.frame_checked     = cmd.check;
        result_next.connected         = link_next;
        result_next.in_bits_high_volt = high_next;
        result_next.in_bits_low_volt  = low_next;
        result_next.error_count       = errors_next;
    end

    spi_ife_oreg u_oreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result_next),
        .i_take   (o_out.ready),
        .o_valid  (oreg_valid),
        .o_free   (oreg_free),
        .o_result (result_q)
    );

    assign o_out.valid             = oreg_valid;
    assign o_out.send_strobe       = result_q.send_strobe;
    assign o_out.send_byte         = result_q.send_byte;
    assign o_out.select_active     = result_q.select_active;
    assign o_out.frame_checked     = result_q.frame_checked;
    assign o_out.connected         = result_q.connected;
    assign o_out.in_bits_high_volt = result_q.in_bits_high_volt;
    assign o_out.in_bits_low_volt  = result_q.in_bits_low_volt;
    assign o_out.error_count       = result_q.error_count;

endmodule
`default_nettype wire

FILE: rtl/spi_ife_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_ctrl
// Frame sequencer: build, transfer, idle and check phases with byte counter.
// ----------------------------------------------------------------------------
module spi_ife_ctrl #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire                  i_link_ready,
    output spi_ife_pkg::t_cmd    o_cmd
);
    import spi_ife_pkg::*;

    localparam logic [1:0] PH_BUILD = 2'd0;
    localparam logic [1:0] PH_XFER  = 2'd1;
    localparam logic [1:0] PH_IDLE  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    localparam logic [BIDX_W-1:0] LP_FB = BIDX_W'(FRAME_BYTES);

    logic [1:0]        r_phase, n_phase;
    logic [BIDX_W-1:0] r_bi, n_bi;
    logic [BIDX_W-1:0] bi_m1;

    assign bi_m1 = r_bi - BIDX_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_bi    = r_bi;
        o_cmd   = '0;
        case (r_phase)
            PH_BUILD: begin
                o_cmd.build = 1'b1;
                n_phase     = PH_XFER;
                n_bi        = '0;
            end
            PH_XFER: begin
                if (r_bi == '0) begin
                    // The first byte goes out without waiting for the link.
                    n_bi         = BIDX_W'(1);
                    o_cmd.send   = 1'b1;
                    o_cmd.tx_idx = '0;
                end else if (i_link_ready) begin
                    o_cmd.store_rx = 1'b1;
                    o_cmd.rx_idx   = bi_m1[FIDX_W-1:0];
                    n_bi           = r_bi + BIDX_W'(1);
                    if (n_bi > LP_FB) begin
                        n_phase = PH_IDLE;
                    end else begin
                        o_cmd.send   = 1'b1;
                        o_cmd.tx_idx = r_bi[FIDX_W-1:0];
                    end
                end
            end
            PH_IDLE: begin
                n_phase = PH_CHECK;
            end
            PH_CHECK: begin
                o_cmd.check = 1'b1;
                n_phase     = PH_BUILD;
            end
            default: begin
                n_phase = PH_BUILD;
            end
        endcase
        o_cmd.select = (n_phase != PH_BUILD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BUILD;
            r_bi    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bi    <= n_bi;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/spi_ife_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_dpath
// Frame datapath: transmit frame, receive checksum, link timer and counters.
// ----------------------------------------------------------------------------
module spi_ife_dpath #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  spi_ife_pkg::t_cmd    i_cmd,
    input  wire  [7:0]           i_received_byte,
    input  wire  [7:0]           i_out_bits_a,
    input  wire  [7:0]           i_out_bits_b,
    input  wire                  i_cfg_we,
    input  wire  [15:0]          i_cfg_wdata,
    output logic [7:0]           o_send_byte,
    output logic                 o_link_next,
    output logic [7:0]           o_high_next,
    output logic [7:0]           o_low_next,
    output logic [15:0]          o_errors_next
);
    import spi_ife_pkg::*;

    localparam logic [FIDX_W-1:0] LP_CK_LO = FIDX_W'(FRAME_BYTES - 2);
    localparam logic [FIDX_W-1:0] LP_CK_HI = FIDX_W'(FRAME_BYTES - 1);

    logic [15:0] r_timeout_cfg;

    // Transmit frame: only the two data bytes and the checksum vary.
    logic [7:0]  r_tx_a, r_tx_b;
    logic [15:0] r_tx_ck;

    // Receive frame: the bytes the check needs plus a running sum.
    logic [7:0]  r_rx_1, r_rx_2, r_rx_3, r_rx_lo, r_rx_hi;
    logic [15:0] r_rx_sum;

    logic [15:0] r_timer, n_timer;
    logic        r_link, n_link;
    logic [7:0]  r_high, n_high, r_low, n_low;
    logic [15:0] r_errors, n_errors;
    logic [7:0]  tx_sel;
    logic        frame_good;

    always_comb begin
        if (i_cmd.tx_idx == '0) begin
            tx_sel = TX_MARKER;
        end else if (i_cmd.tx_idx == FIDX_W'(1)) begin
            tx_sel = r_tx_a;
        end else if (i_cmd.tx_idx == FIDX_W'(2)) begin
            tx_sel = r_tx_b;
        end else if (i_cmd.tx_idx == LP_CK_LO) begin
            tx_sel = r_tx_ck[7:0];
        end else if (i_cmd.tx_idx == LP_CK_HI) begin
            tx_sel = r_tx_ck[15:8];
        end else begin
            tx_sel = 8'h00;
        end
    end

    assign o_send_byte = i_cmd.send ? tx_sel : 8'h00;

    assign frame_good = (r_rx_1 == RX_MARKER) && ({r_rx_hi, r_rx_lo} == ~r_rx_sum);

    always_comb begin
        n_timer  = r_timer;
        n_link   = r_link;
        n_high   = r_high;
        n_low    = r_low;
        n_errors = r_errors;
        if (i_cmd.check) begin
            if (frame_good) begin
                n_high  = r_rx_2;
                n_low   = r_rx_3;
                n_timer = '0;
                n_link  = 1'b1;
            end else begin
                n_errors = r_errors + 16'd1;
            end
        end
        if (n_timer < r_timeout_cfg) begin
            n_timer = n_timer + 16'd1;
        end else begin
            n_link = 1'b0;
        end
    end

    assign o_link_next   = n_link;
    assign o_high_next   = n_high;
    assign o_low_next    = n_low;
    assign o_errors_next = n_errors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_cfg <= LINK_TIMEOUT_RST;
            r_timer       <= '0;
            r_link        <= 1'b0;
            r_high        <= '0;
            r_low         <= '0;
            r_errors      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout_cfg <= i_cfg_wdata;
            end
            if (i_step) begin
                r_timer  <= n_timer;
                r_link   <= n_link;
                r_high   <= n_high;
                r_low    <= n_low;
                r_errors <= n_errors;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_cmd.build) begin
            r_tx_a   <= i_out_bits_a;
            r_tx_b   <= i_out_bits_b;
            r_tx_ck  <= ~(16'(TX_MARKER) + 16'(i_out_bits_a) + 16'(i_out_bits_b));
            r_rx_sum <= '0;
        end
        if (i_step && i_cmd.store_rx) begin
            if (i_cmd.rx_idx < LP_CK_LO) begin
                r_rx_sum <= r_rx_sum + 16'(i_received_byte);
            end
            if (i_cmd.rx_idx == FIDX_W'(1)) begin
                r_rx_1 <= i_received_byte;
            end
            if (i_cmd.rx_idx == FIDX_W'(2)) begin
                r_rx_2 <= i_received_byte;
            end
            if (i_cmd.rx_idx == FIDX_W'(3)) begin
                r_rx_3 <= i_received_byte;
            end
            if (i_cmd.rx_idx == LP_CK_LO) begin
                r_rx_lo <= i_received_byte;
            end
            if (i_cmd.rx_idx == LP_CK_HI) begin
                r_rx_hi <= i_received_byte;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/spi_ife_oreg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ife_oreg
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module spi_ife_oreg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  spi_ife_pkg::t_result i_result,
    input  wire                  i_take,
    output logic                 o_valid,
    output logic                 o_free,
    output spi_ife_pkg::t_result o_result
);
    import spi_ife_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_free   = !r_valid || i_take;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

FILE: sim/spi_ife_checker.sv
// ----------------------------------------------------------------------------
// spi_ife_checker
// Watches both channels of the frame exchange master, predicts each result
// from the accepted requests and compares it field by field.
// ----------------------------------------------------------------------------
module spi_ife_checker #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    spi_ife_in_if       i_in_mon,
    spi_ife_out_if      i_out_mon,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    import spi_ife_pkg::*;

    typedef enum logic [1:0] {PH_BUILD, PH_XFER, PH_IDLE, PH_CHECK} t_seq_phase;

    t_seq_phase        seq_phase;
    logic [4:0]        byte_cnt;
    logic [15:0][7:0]  tx_frame;
    logic [15:0][7:0]  rx_frame;
    logic [15:0]       link_timer;
    logic [15:0]       link_timeout;
    logic              link_up;
    logic [7:0]        high_volt_in;
    logic [7:0]        low_volt_in;
    logic [15:0]       bad_frame_count;
    t_result           result_q[$];
    int                fail_total = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    // Complement of the 16-bit sum of the bytes ahead of the checksum.
    function automatic logic [15:0] body_checksum(input logic [15:0][7:0] frm);
        logic [15:0] total;
        total = '0;
        for (int i = 0; i + 2 < FRAME_BYTES; i++) begin
            total += 16'(frm[i]);
        end
        return ~total;
    endfunction

    // Advances the sequencer by one tick and returns the result it causes.
    function automatic t_result predict_tick(input logic rdy, input logic [7:0] rx,
                                             input logic [7:0] out_a,
                                             input logic [7:0] out_b);
        t_result     r;
        logic [15:0] csum;
        logic [3:0]  pos;
        r = '0;
        case (seq_phase)
            PH_BUILD: begin
                tx_frame    = '0;
                tx_frame[0] = TX_MARKER;
                tx_frame[1] = out_a;
                tx_frame[2] = out_b;
                csum = body_checksum(tx_frame);
                tx_frame[FRAME_BYTES-2] = csum[7:0];
                tx_frame[FRAME_BYTES-1] = csum[15:8];
                seq_phase = PH_XFER;
                byte_cnt  = '0;
            end
            PH_XFER: begin
                if (byte_cnt == 5'd0) begin
                    // The first byte goes out without waiting for the link.
                    byte_cnt      = 5'd1;
                    r.send_strobe = 1'b1;
                    r.send_byte   = tx_frame[0];
                end else if (rdy) begin
                    pos = 4'(byte_cnt - 5'd1);
                    rx_frame[pos] = rx;
                    byte_cnt = byte_cnt + 5'd1;
                    if (byte_cnt > 5'(FRAME_BYTES)) begin
                        seq_phase = PH_IDLE;
                    end else begin
                        pos = 4'(byte_cnt - 5'd1);
                        r.send_strobe = 1'b1;
                        r.send_byte   = tx_frame[pos];
                    end
                end
            end
            PH_IDLE: begin
                seq_phase = PH_CHECK;
            end
            default: begin
                r.frame_checked = 1'b1;
                csum = {rx_frame[FRAME_BYTES-1], rx_frame[FRAME_BYTES-2]};
                if (rx_frame[1] != RX_MARKER || csum != body_checksum(rx_frame)) begin
                    bad_frame_count = bad_frame_count + 16'd1;
                end else begin
                    high_volt_in = rx_frame[2];
                    low_volt_in  = rx_frame[3];
                    link_timer   = '0;
                    link_up      = 1'b1;
                end
                seq_phase = PH_BUILD;
            end
        endcase

        // The timer runs after the phase action, so a zero timeout drops the
        // link on the very tick of a good frame.
        if (link_timer < link_timeout) begin
            link_timer = link_timer + 16'd1;
        end else begin
            link_up = 1'b0;
        end

        r.select_active     = (seq_phase != PH_BUILD);
        r.connected         = link_up;
        r.in_bits_high_volt = high_volt_in;
        r.in_bits_low_volt  = low_volt_in;
        r.error_count       = bad_frame_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            seq_phase       = PH_BUILD;
            byte_cnt        = '0;
            tx_frame        = '0;
            rx_frame        = '0;
            link_timer      = '0;
            link_timeout    = LINK_TIMEOUT_RST;
            link_up         = 1'b0;
            high_volt_in    = '0;
            low_volt_in     = '0;
            bad_frame_count = '0;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                link_timeout = i_cfg_wdata;
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                result_q.push_back(predict_tick(i_in_mon.link_ready,
                                                i_in_mon.received_byte,
                                                i_in_mon.out_bits_a,
                                                i_in_mon.out_bits_b));
            end
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result arrived with no request outstanding", $time);
                    fail_total++;
                end else begin
                    want = result_q.pop_front();
                    check_field("send_strobe", 16'(want.send_strobe),
                                16'(i_out_mon.send_strobe));
                    check_field("send_byte", 16'(want.send_byte),
                                16'(i_out_mon.send_byte));
                    check_field("select_active", 16'(want.select_active),
                                16'(i_out_mon.select_active));
                    check_field("frame_checked", 16'(want.frame_checked),
                                16'(i_out_mon.frame_checked));
                    check_field("connected", 16'(want.connected),
                                16'(i_out_mon.connected));
                    check_field("in_bits_high_volt", 16'(want.in_bits_high_volt),
                                16'(i_out_mon.in_bits_high_volt));
                    check_field("in_bits_low_volt", 16'(want.in_bits_low_volt),
                                16'(i_out_mon.in_bits_low_volt));
                    check_field("error_count", want.error_count, i_out_mon.error_count);
                end
            end
        end
        pending_count = result_q.size();
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the SPI I/O frame exchange master.
// ----------------------------------------------------------------------------
// Requests are grouped into whole frame exchanges, so that the sequencer sees
// realistic traffic: a build tick, the tick that starts the first byte, one
// link-ready tick per received byte (with link-not-ready ticks in between),
// the idle tick and the check tick. The received bytes of each exchange form
// a good frame, a frame with a bad marker, a frame with a bad checksum, or
// plain noise. A short directed part opens the run; the random part then runs
// under several link timeout settings, zero and the maximum among them. The
// checker beside the block predicts and compares every result; this module
// only drives stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import spi_ife_pkg::*;

    localparam int unsigned FRAME_BYTES = 6;
    // Requests of random traffic per timeout setting.
    localparam int PHASE_ITEMS = 170;
    // A run is under 2000 requests, each held up by at most a sender gap and
    // by receiver stalls; the limit leaves a wide margin on top of that.
    localparam int unsigned LIMIT = 200000;

    typedef enum {FR_GOOD, FR_BAD_MARKER, FR_BAD_SUM, FR_NOISE} t_frame_kind;
    typedef enum {RX_FLOW, RX_RANDOM, RX_PATTERN} t_stall_mode;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned cycle_count = 0;

    spi_ife_in_if  in_ch ();
    spi_ife_out_if out_ch ();

    spi_io_frame_exchange #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    spi_ife_checker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) frame_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // The receiver switches its stall behavior among full flow, random stalls,
    // and a rotating bit pattern that stalls on a fixed rhythm. The pattern
    // always has at least one ready bit.
    t_stall_mode stall_mode = RX_FLOW;
    int          stall_left = 0;
    logic [7:0]  stall_pat  = 8'hFF;

    initial out_ch.ready = 1'b0;

    always @(negedge clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 2))
                0: stall_mode = RX_FLOW;
                1: stall_mode = RX_RANDOM;
                default: stall_mode = RX_PATTERN;
            endcase
            stall_left = $urandom_range(20, 150);
            stall_pat  = 8'($urandom_range(1, 255));
        end else begin
            stall_left--;
        end
        case (stall_mode)
            RX_FLOW: out_ch.ready <= 1'b1;
            RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: begin
                out_ch.ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[7:1]};
            end
        endcase
    end

    // Writes the checksum of the frame body into the last two bytes, low
    // byte first.
    function automatic logic [15:0][7:0] with_checksum(input logic [15:0][7:0] frm);
        logic [15:0] total;
        total = '0;
        for (int i = 0; i + 2 < FRAME_BYTES; i++) begin
            total += 16'(frm[i]);
        end
        total = ~total;
        frm[FRAME_BYTES-2] = total[7:0];
        frm[FRAME_BYTES-1] = total[15:8];
        return frm;
    endfunction

    function automatic logic [15:0][7:0] make_rx_frame(input t_frame_kind kind);
        logic [15:0][7:0] frm;
        for (int i = 0; i < 16; i++) begin
            frm[i] = 8'($urandom);
        end
        if (kind == FR_NOISE) begin
            return frm;
        end
        frm[1] = RX_MARKER;
        frm = with_checksum(frm);
        if (kind == FR_BAD_MARKER) begin
            // The checksum still matches, so only the marker is wrong.
            frm[1] = RX_MARKER ^ 8'($urandom_range(1, 255));
            frm = with_checksum(frm);
        end else if (kind == FR_BAD_SUM) begin
            frm[FRAME_BYTES-2] = frm[FRAME_BYTES-2] ^ 8'($urandom_range(0, 255));
            frm[FRAME_BYTES-1] = frm[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
        end
        return frm;
    endfunction

    // Sender gap: valid stays low while the payload wanders, so a block that
    // takes a request without valid shows up as a mismatch.
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            in_ch.valid         <= 1'b0;
            in_ch.link_ready    <= 1'($urandom);
            in_ch.received_byte <= 8'($urandom);
            in_ch.out_bits_a    <= 8'($urandom);
            in_ch.out_bits_b    <= 8'($urandom);
            @(negedge clk);
        end
    endtask

    // Presents one request at a falling edge and waits for the rising edge
    // that accepts it. At the end of a burst the sender pauses for a while.
    task automatic send_tick(input logic rdy, input logic [7:0] rx,
                             input logic [7:0] out_a, input logic [7:0] out_b);
        in_ch.valid         <= 1'b1;
        in_ch.link_ready    <= rdy;
        in_ch.received_byte <= rx;
        in_ch.out_bits_a    <= out_a;
        in_ch.out_bits_b    <= out_b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // Mostly short bursts; now and then a long one with no gaps.
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 16);
            end
            hold_off($urandom_range(1, 6));
        end
    endtask

    // One whole frame exchange. Before each received byte up to max_hold
    // link-not-ready ticks pass; long_wait extra ones come before the first
    // byte, which is how the link timer gets to run out.
    task automatic run_frame(input logic [15:0][7:0] rx_bytes, input logic [7:0] out_a,
                             input logic [7:0] out_b, input int max_hold,
                             input int long_wait);
        send_tick(1'($urandom), 8'($urandom), out_a, out_b);
        send_tick(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (int k = 0; k < FRAME_BYTES; k++) begin
            int hold;
            hold = $urandom_range(0, max_hold);
            if (k == 0) begin
                hold += long_wait;
            end
            repeat (hold) send_tick(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            send_tick(1'b1, rx_bytes[k], 8'($urandom), 8'($urandom));
        end
        send_tick(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_tick(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic random_frames(input int count);
        int          stop_at;
        int          pick;
        int          long_wait;
        int          max_hold;
        t_frame_kind kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                kind = FR_GOOD;
            end else if (pick < 72) begin
                kind = FR_BAD_MARKER;
            end else if (pick < 86) begin
                kind = FR_BAD_SUM;
            end else begin
                kind = FR_NOISE;
            end
            max_hold  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
            long_wait = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 130) : 0;
            run_frame(make_rx_frame(kind), 8'($urandom), 8'($urandom), max_hold,
                      long_wait);
        end
    endtask

    // The timeout register is only written with the block idle: the sender
    // stops and every outstanding result drains first.
    task automatic write_timeout(input logic [15:0] value);
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [15:0][7:0] frm;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.link_ready    = 1'b0;
        in_ch.received_byte = '0;
        in_ch.out_bits_a    = '0;
        in_ch.out_bits_b    = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a good frame with extreme data and no link waits, then a
        // frame whose checksum is wrong, with the opposite extremes.
        frm    = '0;
        frm[1] = RX_MARKER;
        frm[2] = 8'hFF;
        frm = with_checksum(frm);
        run_frame(frm, 8'hFF, 8'h00, 0, 0);

        frm    = '0;
        frm[0] = 8'hFF;
        frm[1] = RX_MARKER;
        frm[3] = 8'hFF;
        frm = with_checksum(frm);
        frm[FRAME_BYTES-2] = ~frm[FRAME_BYTES-2];
        run_frame(frm, 8'h00, 8'hFF, 1, 0);

        // Random traffic under the reset timeout, then under a zero timeout
        // (the link drops on the tick of a good frame), the maximum, short
        // ones that run out between frames, and the reset value written back.
        random_frames(PHASE_ITEMS);
        write_timeout(16'd0);
        random_frames(PHASE_ITEMS);
        write_timeout(16'hFFFF);
        random_frames(PHASE_ITEMS);
        write_timeout(16'd12);
        random_frames(PHASE_ITEMS);
        write_timeout(16'd1);
        random_frames(PHASE_ITEMS);
        write_timeout(LINK_TIMEOUT_RST);
        random_frames(PHASE_ITEMS);

        // Drain: every result must arrive, then the sender stays quiet in case a
        // stray result is still on its way.
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);

        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
